// ----- rtl/jdc_pkg.sv -----
`timescale 1ns / 1ps

package jdc_pkg;

  typedef enum logic [1:0] {
    MODE_CIVIL   = 2'd0,
    MODE_JULIAN  = 2'd1,
    MODE_DOY     = 2'd2,
    MODE_WEEKDAY = 2'd3
  } mode_t;

  localparam int NUM_STAGES = 11;

  // day number constants
  localparam logic [22:0] JD_OFFSET  = 23'd1721119;
  localparam logic [22:0] JD_FIRST   = 23'd1721426;
  localparam logic [22:0] JD_LAST    = 23'd5373484;
  localparam logic [22:0] BASE_1900  = 23'd2415386;
  localparam logic [17:0] CYCLE_DAYS = 18'd146097;
  localparam logic [10:0] QUAD_DAYS  = 11'd1461;
  localparam logic [7:0]  MONTH_SPAN = 8'd153;
  localparam logic [22:0] CIVIL_BIAS = 23'(1721119 - 146097);

  // march-based index of december
  localparam logic [3:0]  AM_DEC     = 4'd9;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;

  // floor(2^32 / d), quotient estimate is low by at most one
  localparam logic [31:0] RECIP_7     = 32'(64'h1_0000_0000 / 64'd7);
  localparam logic [31:0] RECIP_100   = 32'(64'h1_0000_0000 / 64'd100);
  localparam logic [31:0] RECIP_CYCLE = 32'(64'h1_0000_0000 / 64'd146097);
  localparam logic [31:0] RECIP_QUAD  = 32'(64'h1_0000_0000 / 64'd1461);
  localparam logic [31:0] RECIP_SPAN  = 32'(64'h1_0000_0000 / 64'd153);

  // days in a month, february without leap day
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // (153 * am + 2) / 5 for a march-based month index
  function automatic logic [8:0] month_offset(input logic [3:0] am);
    logic [8:0] ofs;
    case (am)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// ----- rtl/julian_day_date_converter.sv -----
`timescale 1ns / 1ps

// julian day number / gregorian date converter, fully pipelined
// path: an accepted input beat passes through the stage registers s1 to s11 in order to its output beat
// throughput: one beat per cycle; each of the eleven register stages takes a new
//   beat every cycle, a stall holds the run of full stages next to the output only
// reset: rst clears the stage valid bits only, payload registers are not reset
module julian_day_date_converter
  import jdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // month_in[3:0], day_in[12:4], year_in[26:13], julian_in[49:27],
  // target_weekday[52:50], zero fill[55:53]
  input  logic [55:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // julian_out[22:0], month_out[26:23], day_out[31:27], year_out[45:32],
  // weekday_out[48:46], zero fill[55:49]
  output logic [55:0] m_axis_tdata,
  // valid_res[0]
  output logic        m_axis_tuser
);

  // ------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or its
  // successor loads, so a stall only stops the full part of the pipe
  // ------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // stage 1: unpack, pick the march-based year and month offset,
  // start the divisions by 7 and 100
  // ------------------------------------------------------------------
  mode_t       in_mode;
  logic [3:0]  in_month;
  logic [8:0]  in_day;
  logic [13:0] in_year;
  logic [22:0] in_jin;
  logic [2:0]  in_tw;
  logic        in_early;
  logic [3:0]  in_am;
  logic [14:0] in_ay;
  logic [8:0]  in_aoff;
  logic [9:0]  in_dterm;
  logic [55:0] in_p7;
  logic [55:0] in_pay;
  logic [55:0] in_py;

  always_comb begin
    in_mode  = mode_t'(s_axis_tuser);
    in_month = s_axis_tdata[3:0];
    in_day   = s_axis_tdata[12:4];
    in_year  = s_axis_tdata[26:13];
    in_jin   = s_axis_tdata[49:27];
    in_tw    = s_axis_tdata[52:50];
    in_early = in_month <= MONTH_FEB;
    in_am    = in_early ? in_month + 4'd9 : in_month - 4'd3;
    if (in_mode == MODE_DOY) begin
      // 31 dec of the year before, one 400-year cycle up
      in_ay    = 15'(in_year) + 15'd399;
      in_aoff  = month_offset(AM_DEC);
      in_dterm = (in_year == 14'd0) ? 10'(in_day) : 10'(in_day) + 10'd31;
    end else begin
      in_ay    = 15'(in_year) + (in_early ? 15'd399 : 15'd400);
      in_aoff  = month_offset(in_am);
      in_dterm = 10'(in_day);
    end
    in_p7  = 56'(in_jin) * 56'(RECIP_7);
    in_pay = 56'(in_ay) * 56'(RECIP_100);
    in_py  = 56'(in_year) * 56'(RECIP_100);
  end

  mode_t       s1_mode;
  logic [3:0]  s1_month;
  logic [8:0]  s1_day;
  logic [13:0] s1_year;
  logic [22:0] s1_jin;
  logic [2:0]  s1_tw;
  logic [14:0] s1_ay;
  logic [8:0]  s1_aoff;
  logic [9:0]  s1_dterm;
  logic [20:0] s1_q7e;
  logic [7:0]  s1_qay;
  logic [7:0]  s1_qy;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_mode  <= in_mode;
      s1_month <= in_month;
      s1_day   <= in_day;
      s1_year  <= in_year;
      s1_jin   <= in_jin;
      s1_tw    <= in_tw;
      s1_ay    <= in_ay;
      s1_aoff  <= in_aoff;
      s1_dterm <= in_dterm;
      s1_q7e   <= in_p7[52:32];
      s1_qay   <= in_pay[39:32];
      s1_qy    <= in_py[39:32];
    end
  end

  // ------------------------------------------------------------------
  // stage 2: finish the divisions, leap year and date check
  // ------------------------------------------------------------------
  logic [23:0] c2_r7t;
  logic [2:0]  c2_dow;
  logic [14:0] c2_rat;
  logic [6:0]  c2_ra;
  logic [7:0]  c2_qa;
  logic [13:0] c2_ryt;
  logic [6:0]  c2_ry;
  logic [7:0]  c2_qy;
  logic        c2_leap;
  logic [5:0]  c2_len;
  logic        c2_date_ok;
  logic        c2_ok;

  always_comb begin
    c2_r7t = 24'(s1_jin) - 24'(s1_q7e) * 24'd7;
    c2_dow = (c2_r7t >= 24'd7) ? 3'(c2_r7t - 24'd7) : 3'(c2_r7t);

    c2_rat = s1_ay - 15'(s1_qay) * 15'd100;
    if (c2_rat >= 15'd100) begin
      c2_ra = 7'(c2_rat - 15'd100);
      c2_qa = s1_qay + 8'd1;
    end else begin
      c2_ra = 7'(c2_rat);
      c2_qa = s1_qay;
    end

    c2_ryt = s1_year - 14'(s1_qy) * 14'd100;
    if (c2_ryt >= 14'd100) begin
      c2_ry = 7'(c2_ryt - 14'd100);
      c2_qy = s1_qy + 8'd1;
    end else begin
      c2_ry = 7'(c2_ryt);
      c2_qy = s1_qy;
    end

    c2_leap = ((s1_year[1:0] == 2'd0) && (c2_ry != 7'd0))
           || ((c2_ry == 7'd0) && (c2_qy[1:0] == 2'd0));
    c2_len  = 6'(month_len(s1_month))
            + (((s1_month == MONTH_FEB) && c2_leap) ? 6'd1 : 6'd0);
    c2_date_ok = (s1_day != 9'd0) && (s1_month != 4'd0) && (s1_month <= MONTH_MAX)
              && (s1_day <= 9'(c2_len));

    case (s1_mode)
      MODE_CIVIL:   c2_ok = c2_date_ok;
      MODE_WEEKDAY: c2_ok = (s1_tw != 3'd0);
      default:      c2_ok = 1'b1;
    endcase
  end

  mode_t       s2_mode;
  logic [22:0] s2_jin;
  logic [2:0]  s2_tw;
  logic [2:0]  s2_dow;
  logic [6:0]  s2_ra;
  logic [7:0]  s2_qa;
  logic [8:0]  s2_aoff;
  logic [9:0]  s2_dterm;
  logic        s2_yz;
  logic        s2_ok;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_mode  <= s1_mode;
      s2_jin   <= s1_jin;
      s2_tw    <= s1_tw;
      s2_dow   <= c2_dow;
      s2_ra    <= c2_ra;
      s2_qa    <= c2_qa;
      s2_aoff  <= s1_aoff;
      s2_dterm <= s1_dterm;
      s2_yz    <= (s1_year == 14'd0);
      s2_ok    <= c2_ok;
    end
  end

  // ------------------------------------------------------------------
  // stage 3: century and quad-year terms, weekday step back
  // ------------------------------------------------------------------
  logic [17:0] c3_p1;
  logic [25:0] c3_p2;
  logic [3:0]  c3_v;
  logic [2:0]  c3_off;
  logic [22:0] c3_direct;

  always_comb begin
    c3_p1 = 18'(s2_ra) * 18'(QUAD_DAYS);
    c3_p2 = 26'(s2_qa) * 26'(CYCLE_DAYS);
    // (dow + 7 - (tw - 1)) mod 7, the sum stays below 15
    c3_v  = 4'(s2_dow) + 4'd8 - 4'(s2_tw);
    if (c3_v >= 4'd14) begin
      c3_off = 3'(c3_v - 4'd14);
    end else if (c3_v >= 4'd7) begin
      c3_off = 3'(c3_v - 4'd7);
    end else begin
      c3_off = 3'(c3_v);
    end
    if ((s2_mode == MODE_WEEKDAY) && (s2_tw != 3'd0)) begin
      // saturate at day zero
      c3_direct = (s2_jin >= 23'(c3_off)) ? s2_jin - 23'(c3_off) : 23'd0;
    end else begin
      c3_direct = s2_jin;
    end
  end

  mode_t       s3_mode;
  logic        s3_yz;
  logic        s3_ok;
  logic [22:0] s3_direct;
  logic [15:0] s3_t1;
  logic [23:0] s3_t2;
  logic [8:0]  s3_aoff;
  logic [9:0]  s3_dterm;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_mode   <= s2_mode;
      s3_yz     <= s2_yz;
      s3_ok     <= s2_ok;
      s3_direct <= c3_direct;
      s3_t1     <= c3_p1[17:2];
      s3_t2     <= c3_p2[25:2];
      s3_aoff   <= s2_aoff;
      s3_dterm  <= s2_dterm;
    end
  end

  // ------------------------------------------------------------------
  // stage 4: day number sum, mode select, year range check
  // ------------------------------------------------------------------
  logic [24:0] c4_sum;
  logic [23:0] c4_base;
  logic [22:0] c4_jd;
  logic        c4_ok;

  always_comb begin
    c4_sum  = 25'(s3_dterm) + 25'(s3_aoff) + 25'(s3_t1) + 25'(s3_t2) + 25'(CIVIL_BIAS);
    c4_base = 24'(s3_dterm) + 24'(BASE_1900);
    case (s3_mode)
      MODE_CIVIL:  c4_jd = s3_ok ? c4_sum[22:0] : 23'd0;
      MODE_DOY:    c4_jd = s3_yz ? c4_base[22:0] : c4_sum[22:0];
      default:     c4_jd = s3_direct;
    endcase
    c4_ok = s3_ok && (c4_jd >= JD_FIRST) && (c4_jd <= JD_LAST);
  end

  logic [22:0] s4_jd;
  logic        s4_ok;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_jd <= c4_jd;
      s4_ok <= c4_ok;
    end
  end

  // ------------------------------------------------------------------
  // stage 5: start of the inverse, estimate 400-year cycle and weekday
  // ------------------------------------------------------------------
  logic [23:0] c5_dj;
  logic [23:0] c5_am1;
  logic [55:0] c5_pb;
  logic [55:0] c5_pw;

  always_comb begin
    c5_dj  = 24'(s4_jd) - 24'(JD_OFFSET);
    c5_am1 = {c5_dj[21:0], 2'b00} - 24'd1;
    c5_pb  = 56'(c5_am1) * 56'(RECIP_CYCLE);
    c5_pw  = 56'(s4_jd) * 56'(RECIP_7);
  end

  logic [23:0] s5_am1;
  logic [7:0]  s5_be;
  logic [20:0] s5_qw;
  logic [22:0] s5_jd;
  logic        s5_ok;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_am1 <= c5_am1;
      s5_be  <= c5_pb[39:32];
      s5_qw  <= c5_pw[52:32];
      s5_jd  <= s4_jd;
      s5_ok  <= s4_ok;
    end
  end

  // ------------------------------------------------------------------
  // stage 6: fix cycle quotient, day within cycle, weekday
  // ------------------------------------------------------------------
  logic [24:0] c6_remt;
  logic [17:0] c6_rem;
  logic [7:0]  c6_b;
  logic [17:0] c6_cp3;
  logic [23:0] c6_rwt;
  logic [2:0]  c6_rw;

  always_comb begin
    c6_remt = 25'(s5_am1) - 25'(s5_be) * 25'(CYCLE_DAYS);
    if (c6_remt >= 25'(CYCLE_DAYS)) begin
      c6_rem = 18'(c6_remt - 25'(CYCLE_DAYS));
      c6_b   = s5_be + 8'd1;
    end else begin
      c6_rem = 18'(c6_remt);
      c6_b   = s5_be;
    end
    c6_cp3 = {c6_rem[17:2], 2'b00} + 18'd3;
    c6_rwt = 24'(s5_jd) - 24'(s5_qw) * 24'd7;
    c6_rw  = (c6_rwt >= 24'd7) ? 3'(c6_rwt - 24'd7) : 3'(c6_rwt);
  end

  logic [7:0]  s6_b;
  logic [17:0] s6_cp3;
  logic [2:0]  s6_wd;
  logic [22:0] s6_jd;
  logic        s6_ok;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_b   <= c6_b;
      s6_cp3 <= c6_cp3;
      s6_wd  <= c6_rw + 3'd1;
      s6_jd  <= s5_jd;
      s6_ok  <= s5_ok;
    end
  end

  // ------------------------------------------------------------------
  // stage 7: estimate year within cycle
  // ------------------------------------------------------------------
  logic [55:0] c7_pq;

  assign c7_pq = 56'(s6_cp3) * 56'(RECIP_QUAD);

  logic [7:0]  s7_b;
  logic [17:0] s7_cp3;
  logic [6:0]  s7_qe;
  logic [2:0]  s7_wd;
  logic [22:0] s7_jd;
  logic        s7_ok;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_b   <= s6_b;
      s7_cp3 <= s6_cp3;
      s7_qe  <= c7_pq[38:32];
      s7_wd  <= s6_wd;
      s7_jd  <= s6_jd;
      s7_ok  <= s6_ok;
    end
  end

  // ------------------------------------------------------------------
  // stage 8: fix year quotient, day of march-based year
  // ------------------------------------------------------------------
  logic [17:0] c8_r1t;
  logic [10:0] c8_r1;
  logic [6:0]  c8_q;
  logic [11:0] c8_g4;
  logic [10:0] c8_h;

  always_comb begin
    c8_r1t = s7_cp3 - 18'(s7_qe) * 18'(QUAD_DAYS);
    if (c8_r1t >= 18'(QUAD_DAYS)) begin
      c8_r1 = 11'(c8_r1t - 18'(QUAD_DAYS));
      c8_q  = s7_qe + 7'd1;
    end else begin
      c8_r1 = 11'(c8_r1t);
      c8_q  = s7_qe;
    end
    c8_g4 = 12'(c8_r1) + 12'd4;
    // e - 3 with e = 5 * ((r1 + 4) >> 2)
    c8_h  = 11'(c8_g4[11:2]) * 11'd5 - 11'd3;
  end

  logic [7:0]  s8_b;
  logic [6:0]  s8_q;
  logic [10:0] s8_h;
  logic [2:0]  s8_wd;
  logic [22:0] s8_jd;
  logic        s8_ok;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s8_b  <= s7_b;
      s8_q  <= c8_q;
      s8_h  <= c8_h;
      s8_wd <= s7_wd;
      s8_jd <= s7_jd;
      s8_ok <= s7_ok;
    end
  end

  // ------------------------------------------------------------------
  // stage 9: estimate march-based month
  // ------------------------------------------------------------------
  logic [55:0] c9_ph;

  assign c9_ph = 56'(s8_h) * 56'(RECIP_SPAN);

  logic [7:0]  s9_b;
  logic [6:0]  s9_q;
  logic [10:0] s9_h;
  logic [3:0]  s9_fe;
  logic [2:0]  s9_wd;
  logic [22:0] s9_jd;
  logic        s9_ok;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s9_b  <= s8_b;
      s9_q  <= s8_q;
      s9_h  <= s8_h;
      s9_fe <= c9_ph[35:32];
      s9_wd <= s8_wd;
      s9_jd <= s8_jd;
      s9_ok <= s8_ok;
    end
  end

  // ------------------------------------------------------------------
  // stage 10: fix month quotient, remainder for the day
  // ------------------------------------------------------------------
  logic [10:0] c10_r2t;
  logic [7:0]  c10_rem2;
  logic [3:0]  c10_f;

  always_comb begin
    c10_r2t = s9_h - 11'(s9_fe) * 11'(MONTH_SPAN);
    if (c10_r2t >= 11'(MONTH_SPAN)) begin
      c10_rem2 = 8'(c10_r2t - 11'(MONTH_SPAN));
      c10_f    = s9_fe + 4'd1;
    end else begin
      c10_rem2 = 8'(c10_r2t);
      c10_f    = s9_fe;
    end
  end

  logic [7:0]  s10_b;
  logic [6:0]  s10_q;
  logic [3:0]  s10_f;
  logic [7:0]  s10_rem2;
  logic [2:0]  s10_wd;
  logic [22:0] s10_jd;
  logic        s10_ok;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s10_b    <= s9_b;
      s10_q    <= s9_q;
      s10_f    <= c10_f;
      s10_rem2 <= c10_rem2;
      s10_wd   <= s9_wd;
      s10_jd   <= s9_jd;
      s10_ok   <= s9_ok;
    end
  end

  // ------------------------------------------------------------------
  // stage 11: civil fields, output register
  // ------------------------------------------------------------------
  logic [15:0] c11_p5;
  logic [4:0]  c11_day;
  logic [13:0] c11_yb;
  logic [13:0] c11_year;
  logic [3:0]  c11_month;

  always_comb begin
    // rem2 / 5 + 1, exact for every 8-bit rem2 value
    c11_p5  = 16'(s10_rem2) * 16'd205;
    c11_day = 5'(c11_p5[15:10]) + 5'd1;
    c11_yb  = 14'(s10_q) + 14'(s10_b) * 14'd100;
    if (s10_f > 4'd9) begin
      c11_month = s10_f - 4'd9;
      c11_year  = c11_yb + 14'd1;
    end else begin
      c11_month = s10_f + 4'd3;
      c11_year  = c11_yb;
    end
  end

  logic [22:0] s11_jd;
  logic [3:0]  s11_month;
  logic [4:0]  s11_day;
  logic [13:0] s11_year;
  logic [2:0]  s11_wd;
  logic        s11_ok;

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      s11_jd    <= s10_jd;
      s11_month <= s10_ok ? c11_month : 4'd0;
      s11_day   <= s10_ok ? c11_day : 5'd0;
      s11_year  <= s10_ok ? c11_year : 14'd0;
      s11_wd    <= s10_wd;
      s11_ok    <= s10_ok;
    end
  end

  assign m_axis_tvalid = vld[NUM_STAGES-1];
  assign m_axis_tdata  = {7'd0, s11_wd, s11_year, s11_day, s11_month, s11_jd};
  assign m_axis_tuser  = s11_ok;

endmodule
